FILE: hw/rtl/gdg_pkg.sv
package gdg_pkg;

  localparam int unsigned GRID_DIM_DEF = 80;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_DEPOSIT = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_GZX   = 2'd0;
  localparam logic [1:0] REG_GZY   = 2'd1;
  localparam logic [1:0] REG_BURST = 2'd2;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [23:0] landing_x;
    logic signed [23:0] landing_y;
    logic [19:0]        spread_sigma;
    logic [39:0]        weight;
    logic [23:0]        arrival_hours;
    logic [3:0]         size_class;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [47:0] cell_dose;
    logic [23:0] cell_arrival;
    logic [3:0]  cell_class;
  } result_t;

  // Shared divider widths: dividend and quotient, divisor.
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 41;

  localparam logic [47:0] DOSE_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [31:0] EXP_SEED   = 32'hFFFF_0000;
  localparam int unsigned EXP_BITS   = 20;
  localparam logic [7:0]  BURST_DIV  = 8'd200;
  localparam logic [7:0]  BURST_HALF = 8'd100;
  // ceil(2^32 / 200), exact for dividends below 2^24.
  localparam logic [24:0] BURST_RECIP = 25'd21474837;

  typedef logic [EXP_BITS-1:0][31:0] exp_tab_t;

  // Successive squares of exp(-2^-16) in Q0.32, one per bit of the exponent.
  function automatic exp_tab_t exp_tab();
    exp_tab_t   tab;
    logic [64:0] sq;
    logic [31:0] c;
    c = EXP_SEED;
    for (int b = 0; b < EXP_BITS; b++) begin
      tab[b] = c;
      sq = 65'(c) * 65'(c) + 65'(33'h0_8000_0000);
      c = sq[63:32];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_C = exp_tab();

endpackage

FILE: hw/rtl/gaussian_deposition_grid.sv
// Gaussian deposition grid: a GRID_DIM x GRID_DIM grid of cells, each with
// a dose rate, a first arrival time and a size class, held in on-chip RAM.
// An item is taken at a clock edge with start high and busy low; busy stays
// high until its result has been formed. Every item yields one result beat
// on res_o, marked by done_o for exactly one cycle; the receiver cannot
// stall, so it must take the beat in that cycle.
// A deposit walks all cells in order, one cell at a time: read, compute,
// write back. A cell at or beyond the cutoff skips the computation; a cell
// inside it makes up to two passes through the shared divider and the
// 20-step exponential loop. The deposit first forms sigma^2 and the cutoff
// in ST_PRE and ST_PRE2.
// A read passes through ST_RD0 and ST_RD1, and through ST_RD2 as well when
// air burst scaling divides the dose by 200, one 16-bit digit per cycle. A
// clear sweeps every cell of the grid. A rejected deposit or an unknown
// command answers without leaving the idle state.
// Reset sets the registers to their defaults and starts the same clearing
// sweep with busy high; configuration writes are taken at any time and
// belong between items.
module gaussian_deposition_grid #(
  parameter int unsigned GRID_DIM = gdg_pkg::GRID_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  gdg_pkg::item_t   item_i,
  output logic             done_o,
  output gdg_pkg::result_t res_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [6:0]       cfg_wdata_i
);

  localparam int unsigned CELLS = GRID_DIM * GRID_DIM;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(GRID_DIM);

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_CLR  = 18'h00002,
    ST_PRE  = 18'h00004,
    ST_PRE2 = 18'h00008,
    ST_CALC = 18'h00010,
    ST_SQ   = 18'h00020,
    ST_SUM  = 18'h00040,
    ST_DIV1 = 18'h00080,
    ST_EXP  = 18'h00100,
    ST_ENRM = 18'h00200,
    ST_WE   = 18'h00400,
    ST_DIV2 = 18'h00800,
    ST_PI1  = 18'h01000,
    ST_PI2  = 18'h02000,
    ST_WR   = 18'h04000,
    ST_RD0  = 18'h08000,
    ST_RD1  = 18'h10000,
    ST_RD2  = 18'h20000
  } state_e;

  state_e           state_q, state_d;
  logic             done_q, done_d;
  gdg_pkg::result_t res_q, res_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CW-1:0]    gx_q, gx_d;
  logic [CW-1:0]    gy_q, gy_d;
  logic [4:0]       bit_q, bit_d;
  logic             clr_res_q, clr_res_d;
  logic [6:0]       gzx_q, gzy_q;
  logic             burst_q;

  gdg_pkg::item_t   item_q;
  logic [39:0]      s2_q;
  logic [44:0]      lim_q;
  logic [24:0]      adx_q, ady_q;
  logic [49:0]      sqx_q, sqy_q;
  logic [19:0]      t_q;
  logic [32:0]      acc_q;
  logic [16:0]      e_q;
  logic [56:0]      q_q;
  logic [55:0]      phi_q;
  logic [62:0]      plo_q;
  logic [47:0]      contrib_q;
  logic [63:0]      bq_q;
  logic [7:0]       brem_q;
  logic [1:0]       bcnt_q;

  logic [47:0]      dose_mem [CELLS];
  logic [23:0]      arrival_mem [CELLS];
  logic [3:0]       class_mem [CELLS];
  logic [47:0]      dose_rd_q;
  logic [23:0]      arrival_rd_q;
  logic [3:0]       class_rd_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr, rd_addr;
  logic [47:0]      wdose;
  logic [23:0]      warrival;
  logic [3:0]       wclass;

  logic                        div_start, div_done;
  logic [gdg_pkg::DIV_NW-1:0]  div_num, div_quo;
  logic [gdg_pkg::DIV_DW-1:0]  div_den;

  logic signed [25:0] dx_w, dy_w;
  logic [50:0]        sum_w;
  logic [64:0]        exp_prod;
  logic [56:0]        we_w;
  logic [56:0]        contrib_w;
  logic [48:0]        dsum_w;
  logic [23:0]        bv_w;
  logic [47:0]        bprod_w;
  logic [15:0]        bqd_w;
  logic [23:0]        brem_w;
  logic               in_grid;
  logic               last_cell;

  gdg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Offsets in Q.8 km; a cell is 2 km wide.
  assign dx_w = ((26'(gx_q) - 26'(gzx_q)) << 9) - 26'(item_q.landing_x);
  assign dy_w = ((26'(gy_q) - 26'(gzy_q)) << 9) - 26'(item_q.landing_y);

  assign sum_w     = 51'(sqx_q) + 51'(sqy_q);
  assign exp_prod  = 65'(acc_q) * 65'(gdg_pkg::EXP_C[bit_q]);
  assign we_w      = 57'(item_q.weight) * 57'(e_q);
  assign contrib_w = 57'(phi_q) + 57'(plo_q[62:32]);
  assign dsum_w    = 49'(dose_rd_q) + 49'(contrib_q);
  assign last_cell = addr_q == AW'(CELLS - 1);
  assign in_grid   = (9'(item_q.cell_col) < 9'(GRID_DIM)) &&
                     (9'(item_q.cell_row) < 9'(GRID_DIM));
  assign rd_addr   = AW'(AW'(item_q.cell_row) * AW'(GRID_DIM)) + AW'(item_q.cell_col);

  // Burst scaling: long division by 200, one 16-bit digit per cycle. The
  // running remainder stays below 200, so each partial dividend is below 2^24.
  assign bv_w    = {brem_q, bq_q[63:48]};
  assign bprod_w = 48'(bv_w) * 48'(gdg_pkg::BURST_RECIP);
  assign bqd_w   = bprod_w[47:32];
  assign brem_w  = bv_w - 24'(bqd_w) * 24'(gdg_pkg::BURST_DIV);

  // Write-back values of one cell.
  always_comb begin
    wdose    = dsum_w[48] ? gdg_pkg::DOSE_MAX : dsum_w[47:0];
    warrival = arrival_rd_q;
    if (item_q.arrival_hours != '0 &&
        (arrival_rd_q == '0 || item_q.arrival_hours < arrival_rd_q)) begin
      warrival = item_q.arrival_hours;
    end
    wclass = (contrib_q != '0) ? item_q.size_class : class_rd_q;
    if (state_q == ST_CLR) begin
      wdose    = '0;
      warrival = '0;
      wclass   = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    res_d     = res_q;
    addr_d    = addr_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    bit_d     = bit_q;
    clr_res_d = clr_res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_q;
    div_start = 1'b0;
    div_num   = 64'(sum_w[44:0]) << 16;
    div_den   = {s2_q, 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          res_d = '0;
          case (item_i.cmd)
            gdg_pkg::CMD_DEPOSIT: begin
              if (item_i.spread_sigma == '0) begin
                res_d.status = 1'b1;
                done_d       = 1'b1;
              end else begin
                state_d = ST_PRE;
              end
            end
            gdg_pkg::CMD_READ: state_d = ST_RD0;
            gdg_pkg::CMD_CLEAR: begin
              state_d   = ST_CLR;
              addr_d    = '0;
              clr_res_d = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (last_cell) begin
          state_d   = ST_IDLE;
          done_d    = clr_res_q;
          res_d     = '0;
          clr_res_d = 1'b0;
        end
      end
      ST_PRE: state_d = ST_PRE2;
      ST_PRE2: begin
        state_d = ST_CALC;
        addr_d  = '0;
        gx_d    = '0;
        gy_d    = '0;
      end
      ST_CALC: begin
        mem_re  = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: state_d = ST_SUM;
      ST_SUM: begin
        // Beyond twelve times 2*sigma^2 the exponential is taken as zero.
        if (sum_w >= 51'(lim_q)) begin
          state_d = ST_WR;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          state_d = ST_EXP;
          bit_d   = '0;
        end
      end
      ST_EXP: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == 5'(gdg_pkg::EXP_BITS - 1)) begin
          state_d = ST_ENRM;
        end
      end
      ST_ENRM: state_d = ST_WE;
      ST_WE: begin
        div_num = 64'(we_w);
        div_den = 41'(s2_q);
        if (e_q == '0) begin
          state_d = ST_WR;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_d = ST_PI1;
        end
      end
      ST_PI1: state_d = ST_PI2;
      ST_PI2: state_d = ST_WR;
      ST_WR: begin
        mem_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (gx_q == CW'(GRID_DIM - 1)) begin
          gx_d = '0;
          gy_d = gy_q + 1'b1;
        end else begin
          gx_d = gx_q + 1'b1;
        end
        if (last_cell) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          res_d   = '0;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_RD0: begin
        if (in_grid) begin
          mem_re   = 1'b1;
          mem_addr = rd_addr;
          state_d  = ST_RD1;
        end else begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          res_d   = '0;
        end
      end
      ST_RD1: begin
        res_d.status       = 1'b0;
        res_d.cell_dose    = dose_rd_q;
        res_d.cell_arrival = arrival_rd_q;
        res_d.cell_class   = class_rd_q;
        if (burst_q) begin
          state_d = ST_RD2;
        end else begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_RD2: begin
        if (bcnt_q == 2'd3) begin
          res_d.cell_dose = {bq_q[31:0], bqd_w};
          state_d         = ST_IDLE;
          done_d          = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      done_q    <= 1'b0;
      addr_q    <= '0;
      gx_q      <= '0;
      gy_q      <= '0;
      bit_q     <= '0;
      clr_res_q <= 1'b0;
      gzx_q     <= 7'd40;
      gzy_q     <= 7'd40;
      burst_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      addr_q    <= addr_d;
      gx_q      <= gx_d;
      gy_q      <= gy_d;
      bit_q     <= bit_d;
      clr_res_q <= clr_res_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gdg_pkg::REG_GZX:   gzx_q   <= cfg_wdata_i;
          gdg_pkg::REG_GZY:   gzy_q   <= cfg_wdata_i;
          gdg_pkg::REG_BURST: burst_q <= cfg_wdata_i[0];
          default:   ;
        endcase
      end
    end
  end

  // Datapath registers of the cell being worked on.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_IDLE && start) begin
      item_q <= item_i;
    end
    case (state_q)
      ST_PRE:  s2_q  <= 40'(item_q.spread_sigma) * 40'(item_q.spread_sigma);
      ST_PRE2: lim_q <= (45'(s2_q) << 4) + (45'(s2_q) << 3);
      ST_CALC: begin
        adx_q <= dx_w[25] ? 25'(-dx_w) : dx_w[24:0];
        ady_q <= dy_w[25] ? 25'(-dy_w) : dy_w[24:0];
      end
      ST_SQ: begin
        sqx_q <= 50'(adx_q) * 50'(adx_q);
        sqy_q <= 50'(ady_q) * 50'(ady_q);
      end
      ST_SUM:  contrib_q <= '0;
      ST_DIV1: begin
        t_q   <= div_quo[19:0];
        acc_q <= 33'h1_0000_0000;
      end
      ST_EXP: begin
        if (t_q[bit_q]) begin
          acc_q <= 33'((exp_prod + 65'(33'h0_8000_0000)) >> 32);
        end
      end
      ST_ENRM: e_q <= 17'((acc_q + 33'h0_0000_8000) >> 16);
      ST_WE:   contrib_q <= '0;
      ST_DIV2: q_q <= div_quo[56:0];
      ST_PI1: begin
        phi_q <= 56'(q_q[56:32]) * 56'(gdg_pkg::INV_PI_Q32);
        plo_q <= 63'(q_q[31:0]) * 63'(gdg_pkg::INV_PI_Q32);
      end
      ST_PI2: begin
        contrib_q <= (contrib_w > 57'(gdg_pkg::DOSE_MAX)) ? gdg_pkg::DOSE_MAX
                                                          : contrib_w[47:0];
      end
      ST_RD1: begin
        bq_q   <= 64'(dose_rd_q) + 64'(gdg_pkg::BURST_HALF);
        brem_q <= '0;
        bcnt_q <= '0;
      end
      ST_RD2: begin
        bq_q   <= {bq_q[47:0], bqd_w};
        brem_q <= brem_w[7:0];
        bcnt_q <= bcnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dose_mem[mem_addr]    <= wdose;
      arrival_mem[mem_addr] <= warrival;
      class_mem[mem_addr]   <= wclass;
    end
    if (mem_re) begin
      dose_rd_q    <= dose_mem[mem_addr];
      arrival_rd_q <= arrival_mem[mem_addr];
      class_rd_q   <= class_mem[mem_addr];
    end
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/gdg_div.sv
module gdg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gdg_pkg::DIV_NW-1:0]    num_i,
  input  logic [gdg_pkg::DIV_DW-1:0]    den_i,
  output logic                          done_o,
  output logic [gdg_pkg::DIV_NW-1:0]    quo_o
);

  localparam int unsigned NW = gdg_pkg::DIV_NW;
  localparam int unsigned DW = gdg_pkg::DIV_DW;
  localparam int unsigned CNTW = $clog2(NW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic            ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts
  // out of the quotient register as quotient bits shift in.
  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/gdg_checker.sv
module gdg_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input gdg_pkg::result_t res_o
);

  // A result beat only ends an item, so the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("accepted item dropped");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start)) else $error("result beat without an item");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status) |->
      (res_o.cell_dose == '0 && res_o.cell_arrival == '0 && res_o.cell_class == '0))
    else $error("rejected deposit carries cell data");

endmodule

bind gaussian_deposition_grid gdg_checker u_gdg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
